// ===== rtl/tomrc_pkg.sv =====
// ----------------------------------------------------------------------------
// tomrc_pkg - shared types and constants of the tile occupancy map
// Request codes, the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package tomrc_pkg;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_MARK  = 2'd1;
  localparam logic [1:0] REQ_TEST  = 2'd2;
  localparam logic [1:0] REQ_POP   = 2'd3;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // controller -> datapath
  typedef struct packed {
    logic load;        // latch request fields
    logic clr_grid;    // zero grid flags and count
    logic bump_count;  // saturating count increment
    logic set_y_first; // row pointer to top row of request
    logic set_y_pop;   // row pointer to first non-empty row
    logic set_hit;     // force hit
    logic y_inc;       // advance row pointer
    logic mark_wr;     // OR mask into current row
    logic test_chk;    // accumulate overlap of current row
    logic pop_find;    // take run of first row, clear it
    logic pop_chk;     // clear run from matching lower row
    logic emit;        // load result registers
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] req;
    logic       empty;
    logic       count_zero;
    logic       tile_en;
    logic       grid_empty;
    logic       y_last;
    logic       y_bottom;
    logic       row_hit;
    logic       strip_match;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/tomrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tomrc_ctrl - request sequencer
// Walks the rows of a request and issues datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module tomrc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire tomrc_pkg::sts_t sts,
  output tomrc_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_MRD   = 4'd2;
  localparam logic [3:0] S_MWR   = 4'd3;
  localparam logic [3:0] S_TRD   = 4'd4;
  localparam logic [3:0] S_TCHK  = 4'd5;
  localparam logic [3:0] S_PRD   = 4'd6;
  localparam logic [3:0] S_PFIND = 4'd7;
  localparam logic [3:0] S_PRD2  = 4'd8;
  localparam logic [3:0] S_PCHK  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    busy       = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.req)
          tomrc_pkg::REQ_CLEAR: begin
            cmd.clr_grid = 1'b1;
            state_next   = S_DONE;
          end
          tomrc_pkg::REQ_MARK: begin
            cmd.bump_count = 1'b1;
            if (sts.empty) begin
              state_next = S_DONE;
            end else begin
              cmd.set_y_first = 1'b1;
              state_next      = S_MRD;
            end
          end
          tomrc_pkg::REQ_TEST: begin
            if (sts.count_zero || sts.empty || !sts.tile_en) begin
              cmd.set_hit = !sts.count_zero && !sts.tile_en;
              state_next  = S_DONE;
            end else begin
              cmd.set_y_first = 1'b1;
              state_next      = S_TRD;
            end
          end
          default: begin
            if (sts.grid_empty) begin
              state_next = S_DONE;
            end else begin
              cmd.set_y_pop = 1'b1;
              state_next    = S_PRD;
            end
          end
        endcase
      end
      S_MRD: state_next = S_MWR;
      S_MWR: begin
        cmd.mark_wr = 1'b1;
        if (sts.y_last) begin
          state_next = S_DONE;
        end else begin
          cmd.y_inc  = 1'b1;
          state_next = S_MRD;
        end
      end
      S_TRD: state_next = S_TCHK;
      S_TCHK: begin
        cmd.test_chk = 1'b1;
        if (sts.y_last || sts.row_hit) begin
          state_next = S_DONE;
        end else begin
          cmd.y_inc  = 1'b1;
          state_next = S_TRD;
        end
      end
      S_PRD: state_next = S_PFIND;
      S_PFIND: begin
        cmd.pop_find = 1'b1;
        if (sts.y_bottom) begin
          state_next = S_DONE;
        end else begin
          cmd.y_inc  = 1'b1;
          state_next = S_PRD2;
        end
      end
      S_PRD2: state_next = S_PCHK;
      S_PCHK: begin
        if (!sts.strip_match) begin
          state_next = S_DONE;
        end else begin
          cmd.pop_chk = 1'b1;
          if (sts.y_bottom) begin
            state_next = S_DONE;
          end else begin
            cmd.y_inc  = 1'b1;
            state_next = S_PRD2;
          end
        end
      end
      S_DONE: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/tomrc_dp.sv =====
// ----------------------------------------------------------------------------
// tomrc_dp - occupancy grid datapath
// Row memory with per-row non-empty flags, mask and run logic, count, results.
// ----------------------------------------------------------------------------
`default_nettype none

module tomrc_dp #(
  parameter int GRID_SIZE = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire tomrc_pkg::cmd_t cmd,
  output tomrc_pkg::sts_t      sts,
  input  wire logic [1:0]      req_type,
  input  wire logic [4:0]      col_first,
  input  wire logic [4:0]      row_first,
  input  wire logic [4:0]      col_last,
  input  wire logic [4:0]      row_last,
  input  wire logic            cfg_write,
  input  wire logic            cfg_data,
  output logic                 done,
  output logic                 hit,
  output logic                 rect_valid,
  output logic [4:0]           rect_col,
  output logic [4:0]           rect_row,
  output logic [5:0]           rect_width,
  output logic [5:0]           rect_height,
  output logic [15:0]          marked_count
);

  localparam int CW = $clog2(GRID_SIZE);
  localparam int HW = $clog2(GRID_SIZE + 1);
  localparam logic [CW-1:0] Y_BOTTOM = CW'(GRID_SIZE - 1);

  typedef logic [GRID_SIZE-1:0] row_t;

  function automatic logic [CW-1:0] clamp(logic [4:0] v);
    logic [CW-1:0] r;
    if ({1'b0, v} > 6'(GRID_SIZE - 1)) begin
      r = Y_BOTTOM;
    end else begin
      r = CW'(v);
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] onehot_idx(row_t v);
    logic [CW-1:0] r;
    r = '0;
    for (int i = 0; i < GRID_SIZE; i++) begin
      if (v[i]) begin
        r = r | CW'(i);
      end
    end
    return r;
  endfunction

  row_t          mem [GRID_SIZE];
  row_t          rdata;
  logic          rnz;
  row_t          nz;
  logic [1:0]    req_q;
  logic [CW-1:0] c0, r0, c1, r1;
  logic [CW-1:0] y, y0;
  logic [15:0]   count;
  logic          tile_en;
  logic          hit_q;
  logic          found;
  row_t          strip, low;
  logic [HW-1:0] hcnt;

  row_t          row_q, span, nz_low;
  row_t          low_now, strip_now, strip_top;
  row_t          mem_wdata;
  logic          mem_we;
  logic [CW-1:0] xs, xe;
  logic [HW-1:0] width;

  assign row_q = rnz ? rdata : '0;

  always_comb begin
    for (int i = 0; i < GRID_SIZE; i++) begin
      span[i] = (CW'(i) >= c0) && (CW'(i) <= c1);
    end
  end

  // isolate lowest set bit, then the run that starts there
  assign nz_low    = nz & (~nz + row_t'(1));
  assign low_now   = row_q & (~row_q + row_t'(1));
  assign strip_now = (row_q ^ (row_q + low_now)) & row_q;
  assign strip_top = strip & ~(strip >> 1);
  assign xs        = onehot_idx(low);
  assign xe        = onehot_idx(strip_top);
  assign width     = HW'(xe) - HW'(xs) + HW'(1);

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = row_q;
    if (cmd.mark_wr) begin
      mem_we    = 1'b1;
      mem_wdata = row_q | span;
    end else if (cmd.pop_find) begin
      mem_we    = 1'b1;
      mem_wdata = row_q & ~strip_now;
    end else if (cmd.pop_chk) begin
      mem_we    = 1'b1;
      mem_wdata = row_q & ~strip;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[y] <= mem_wdata;
    end
    rdata <= mem[y];
    rnz   <= nz[y];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nz      <= '0;
      count   <= '0;
      tile_en <= 1'b1;
      done    <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cfg_write) begin
        tile_en <= cfg_data;
      end
      if (cmd.clr_grid) begin
        nz    <= '0;
        count <= '0;
      end else begin
        if (mem_we) begin
          nz[y] <= (mem_wdata != '0);
        end
        if (cmd.bump_count && (count != tomrc_pkg::COUNT_MAX)) begin
          count <= count + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req_type;
      c0    <= clamp(col_first);
      r0    <= clamp(row_first);
      c1    <= clamp(col_last);
      r1    <= clamp(row_last);
      hit_q <= 1'b0;
      found <= 1'b0;
    end
    if (cmd.set_hit || (cmd.test_chk && sts.row_hit)) begin
      hit_q <= 1'b1;
    end
    if (cmd.set_y_first) begin
      y <= r0;
    end else if (cmd.set_y_pop) begin
      y  <= onehot_idx(nz_low);
      y0 <= onehot_idx(nz_low);
    end else if (cmd.y_inc) begin
      y <= y + CW'(1);
    end
    if (cmd.pop_find) begin
      strip <= strip_now;
      low   <= low_now;
      hcnt  <= HW'(1);
      found <= 1'b1;
    end else if (cmd.pop_chk) begin
      hcnt <= hcnt + HW'(1);
    end
    if (cmd.emit) begin
      hit          <= (req_q == tomrc_pkg::REQ_TEST) && hit_q;
      rect_valid   <= found;
      rect_col     <= found ? 5'(xs) : 5'd0;
      rect_row     <= found ? 5'(y0) : 5'd0;
      rect_width   <= found ? 6'(width) : 6'd0;
      rect_height  <= found ? 6'(hcnt) : 6'd0;
      marked_count <= count;
    end
  end

  always_comb begin
    sts.req         = req_q;
    sts.empty       = (c0 > c1) || (r0 > r1);
    sts.count_zero  = (count == '0);
    sts.tile_en     = tile_en;
    sts.grid_empty  = (nz == '0);
    sts.y_last      = (y == r1);
    sts.y_bottom    = (y == Y_BOTTOM);
    sts.row_hit     = ((row_q & span) != '0);
    sts.strip_match = ((row_q & strip) == strip);
  end

endmodule

`default_nettype wire

// ===== rtl/tile_occupancy_map_rect_cover.sv =====
// ----------------------------------------------------------------------------
// tile_occupancy_map_rect_cover - tile occupancy grid with greedy rect cover
// Clear, mark, test and pop requests over a GRID_SIZE x GRID_SIZE bit grid.
//
//   channel   signals                                   handshake
//   request   req_type, col/row_first, col/row_last     start & !busy
//   result    hit, rect_*, marked_count                 done, one cycle
//   config    cfg_data                                  cfg_write
//
// A request spends a read state and a write or check state on each row visited
// on the single-port row memory: mark visits rows row_first..row_last, test
// stops at the first overlapping row, pop visits the popped rows plus the row
// that ends the run, if the run stops above the last row. An empty rectangle,
// a test answered without lookup and a pop of an empty grid visit no row.
// Reset clears the row flags at once; there is no clearing pass.
// busy is high from accept until done; the result is never held back.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_occupancy_map_rect_cover #(
  parameter int GRID_SIZE = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type,
  input  wire logic [4:0]  col_first,
  input  wire logic [4:0]  row_first,
  input  wire logic [4:0]  col_last,
  input  wire logic [4:0]  row_last,
  input  wire logic        cfg_write,
  input  wire logic        cfg_data,
  output logic             done,
  output logic             hit,
  output logic             rect_valid,
  output logic [4:0]       rect_col,
  output logic [4:0]       rect_row,
  output logic [5:0]       rect_width,
  output logic [5:0]       rect_height,
  output logic [15:0]      marked_count
);

  tomrc_pkg::cmd_t cmd;
  tomrc_pkg::sts_t sts;

  tomrc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  tomrc_dp #(
    .GRID_SIZE (GRID_SIZE)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .req_type     (req_type),
    .col_first    (col_first),
    .row_first    (row_first),
    .col_last     (col_last),
    .row_last     (row_last),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .done         (done),
    .hit          (hit),
    .rect_valid   (rect_valid),
    .rect_col     (rect_col),
    .rect_row     (rect_row),
    .rect_width   (rect_width),
    .rect_height  (rect_height),
    .marked_count (marked_count)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    done |-> !(hit && rect_valid))
    else $error("hit and rect_valid both set");

endmodule

`default_nettype wire
